/* hw/rtl/mcmp_pkg.sv */
package mcmp_pkg;

	typedef logic [2:0] event_kind_t;

	localparam event_kind_t KIND_NOTE_ON    = 3'd0;
	localparam event_kind_t KIND_NOTE_OFF   = 3'd1;
	localparam event_kind_t KIND_CONTROLLER = 3'd2;
	localparam event_kind_t KIND_BEND       = 3'd3;
	localparam event_kind_t KIND_PROGRAM    = 3'd4;
	localparam event_kind_t KIND_PRESSURE   = 3'd5;

	localparam logic [3:0] CMD_NOTE_OFF   = 4'h8;
	localparam logic [3:0] CMD_NOTE_ON    = 4'h9;
	localparam logic [3:0] CMD_CONTROLLER = 4'hB;
	localparam logic [3:0] CMD_PROGRAM    = 4'hC;
	localparam logic [3:0] CMD_PRESSURE   = 4'hD;
	localparam logic [3:0] CMD_BEND       = 4'hE;

	localparam logic [7:0] REALTIME_FIRST = 8'hF8;

	// Data bytes that a status byte calls for; zero for any status other than 8x, 9x, Bx, Cx, Dx and Ex.
	function automatic logic [1:0] data_count(input logic [7:0] status);
		logic [1:0] n;
		begin
			case (status[7:4])
				CMD_PROGRAM, CMD_PRESSURE: n = 2'd1;
				CMD_NOTE_OFF, CMD_NOTE_ON, CMD_CONTROLLER, CMD_BEND: n = 2'd2;
				default: n = 2'd0;
			endcase
			return n;
		end
	endfunction

endpackage

/* hw/rtl/midi_channel_message_parser_unit.sv */
// MIDI channel message parser with running status. One raw byte is taken per
// word on the input channel; a completed note on, note off, controller, pitch
// bend, program change or channel pressure message yields one event word.
// Bytes from 0xF8 upwards are dropped without touching the parser state, and
// a 9x message with velocity zero is reported as note off. The block accepts
// one byte every cycle: a byte waits in the input register while the decode
// updates the running status, and the event of a final byte is then loaded
// into the result register, from which it is offered on the output. The rate
// drops only while the output side stalls a waiting event and the byte in the
// input register would complete another.
module midi_channel_message_parser_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           midi_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mcmp_pkg::event_kind_t event_kind,
	output logic [3:0]           channel,
	output logic [6:0]           key_or_param,
	output logic signed [13:0]   event_value
);
	import mcmp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic [7:0]  held_status_q;
	logic [1:0]  pending_q;
	logic [6:0]  first_data_q;

	logic        out_valid_q;
	event_kind_t kind_q;
	logic [3:0]  channel_q;
	logic [6:0]  key_q;
	logic [13:0] value_q;

	logic [7:0]  held_nxt;
	logic [1:0]  pending_nxt;
	logic [6:0]  first_nxt;
	logic        produce;
	event_kind_t kind_nxt;
	logic [6:0]  key_nxt;
	logic [13:0] value_nxt;
	logic        advance;

	always_comb begin
		logic [1:0] pend;
		logic [1:0] n;
		logic [6:0] d;
		held_nxt    = held_status_q;
		pending_nxt = pending_q;
		first_nxt   = first_data_q;
		produce     = 1'b0;
		kind_nxt    = KIND_NOTE_ON;
		key_nxt     = 7'd0;
		value_nxt   = 14'd0;
		pend        = pending_q;
		n           = 2'd0;
		d           = byte_s1[6:0];
		if (byte_s1[7]) begin
			if (byte_s1 < REALTIME_FIRST) begin
				n = data_count(byte_s1);
				if (n == 2'd0) begin
					held_nxt    = 8'd0;
					pending_nxt = 2'd0;
				end else begin
					held_nxt    = byte_s1;
					pending_nxt = n;
				end
			end
		end else begin
			// A data byte with nothing open re-arms the running status.
			if (pending_q == 2'd0 && held_status_q != 8'd0) begin
				n = data_count(held_status_q);
				pend = n;
				if (n == 2'd0)
					held_nxt = 8'd0;
			end
			if (pend >= 2'd2) begin
				first_nxt   = d;
				pending_nxt = 2'd1;
			end else if (pend == 2'd1) begin
				pending_nxt = 2'd0;
				produce     = 1'b1;
				case (held_status_q[7:4])
					CMD_NOTE_ON: begin
						key_nxt = first_data_q;
						if (d != 7'd0) begin
							kind_nxt  = KIND_NOTE_ON;
							value_nxt = {7'd0, d};
						end else begin
							kind_nxt = KIND_NOTE_OFF;
						end
					end
					CMD_NOTE_OFF: begin
						kind_nxt = KIND_NOTE_OFF;
						key_nxt  = first_data_q;
					end
					CMD_CONTROLLER: begin
						kind_nxt  = KIND_CONTROLLER;
						key_nxt   = first_data_q;
						value_nxt = {7'd0, d};
					end
					CMD_BEND: begin
						// Subtracting 8192 from a 14-bit value flips its top bit.
						kind_nxt  = KIND_BEND;
						value_nxt = {~d[6], d[5:0], first_data_q};
					end
					CMD_PROGRAM: begin
						kind_nxt  = KIND_PROGRAM;
						value_nxt = {7'd0, d};
					end
					CMD_PRESSURE: begin
						kind_nxt  = KIND_PRESSURE;
						value_nxt = {7'd0, d};
					end
					default: produce = 1'b0;
				endcase
			end
		end
	end

	// A byte that yields no event may move on even while the result register is stalled.
	assign advance  = valid_s1 && (!out_valid_q || out_ready || !produce);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			held_status_q <= 8'd0;
			pending_q     <= 2'd0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance) begin
				held_status_q <= held_nxt;
				pending_q     <= pending_nxt;
			end
			if (advance && produce)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= midi_byte;
		if (advance)
			first_data_q <= first_nxt;
		if (advance && produce) begin
			kind_q    <= kind_nxt;
			channel_q <= held_status_q[3:0];
			key_q     <= key_nxt;
			value_q   <= value_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = kind_q;
	assign channel      = channel_q;
	assign key_or_param = key_q;
	assign event_value  = value_q;

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
	import mcmp_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PHASE_BYTES    = 500;

	typedef struct {
		event_kind_t        kind;
		logic [3:0]         chan;
		logic [6:0]         key;
		logic signed [13:0] value;
	} midi_msg_t;

	// Tracks the running status of the byte stream and queues the event that each
	// completed message must produce.
	class midi_event_board;
		logic [7:0] held_status;
		logic [1:0] pending_data;
		logic [6:0] first_data;
		midi_msg_t  awaited_events[$];
		int         mismatches;

		function new();
			held_status  = 8'h00;
			pending_data = 2'd0;
			first_data   = 7'd0;
			mismatches   = 0;
		endfunction

		function void take_status(input logic [7:0] s);
			case (s[7:4])
				CMD_PROGRAM, CMD_PRESSURE: begin
					held_status  = s;
					pending_data = 2'd1;
				end
				CMD_NOTE_OFF, CMD_NOTE_ON, CMD_CONTROLLER, CMD_BEND: begin
					held_status  = s;
					pending_data = 2'd2;
				end
				default: begin
					held_status  = 8'h00;
					pending_data = 2'd0;
				end
			endcase
		endfunction

		function void predict_byte(input logic [7:0] b);
			midi_msg_t  m;
			logic [3:0] cmd;
			logic [6:0] d;
			if (b[7]) begin
				if (b < REALTIME_FIRST)
					take_status(b);
				return;
			end
			if (pending_data == 2'd0) begin
				if (held_status == 8'h00)
					return;
				take_status(held_status);
			end
			d = b[6:0];
			if (pending_data == 2'd2) begin
				first_data   = d;
				pending_data = 2'd1;
				return;
			end
			pending_data = 2'd0;
			cmd     = held_status[7:4];
			m.chan  = held_status[3:0];
			m.key   = 7'd0;
			m.value = 14'sd0;
			if (cmd == CMD_NOTE_ON && d != 7'd0) begin
				m.kind  = KIND_NOTE_ON;
				m.key   = first_data;
				m.value = {7'd0, d};
			end else if (cmd == CMD_NOTE_OFF || cmd == CMD_NOTE_ON) begin
				m.kind = KIND_NOTE_OFF;
				m.key  = first_data;
			end else if (cmd == CMD_CONTROLLER) begin
				m.kind  = KIND_CONTROLLER;
				m.key   = first_data;
				m.value = {7'd0, d};
			end else if (cmd == CMD_BEND) begin
				// The 14-bit bend value is centred on 8192.
				m.kind  = KIND_BEND;
				m.value = {d, first_data} - 14'd8192;
			end else if (cmd == CMD_PROGRAM) begin
				m.kind  = KIND_PROGRAM;
				m.value = {7'd0, d};
			end else begin
				m.kind  = KIND_PRESSURE;
				m.value = {7'd0, d};
			end
			awaited_events.push_back(m);
		endfunction

		function void check_event(input event_kind_t kind, input logic [3:0] chan,
				input logic [6:0] key, input logic signed [13:0] value);
			midi_msg_t m;
			if (awaited_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected event: kind %0d chan %0d key %0d value %0d",
						kind, chan, key, value);
				return;
			end
			m = awaited_events.pop_front();
			if (m.kind !== kind || m.chan !== chan || m.key !== key || m.value !== value) begin
				mismatches++;
				if (mismatches <= 10)
					$display("event mismatch: expected kind %0d chan %0d key %0d value %0d, got kind %0d chan %0d key %0d value %0d",
						m.kind, m.chan, m.key, m.value, kind, chan, key, value);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         midi_byte;
	logic               out_valid;
	logic               out_ready;
	event_kind_t        event_kind;
	logic [3:0]         channel;
	logic [6:0]         key_or_param;
	logic signed [13:0] event_value;

	midi_event_board board;
	int              send_idle_pct;
	int              recv_stall_pct;
	int              counted_bytes;
	int              quiet_cycles;

	midi_channel_message_parser_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.midi_byte    (midi_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.event_kind   (event_kind),
		.channel      (channel),
		.key_or_param (key_or_param),
		.event_value  (event_value)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_event(event_kind, channel, key_or_param, event_value);
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Returns at the edge where the word is taken; valid stays high for a following word.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		midi_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.predict_byte(b);
		if (b < REALTIME_FIRST)
			counted_bytes++;
	endtask

	task automatic send_random_message();
		logic [3:0] cmd;
		int         n;
		if ($urandom_range(99) < 10) begin
			send_byte(8'($urandom_range(255)));
			return;
		end
		case ($urandom_range(5))
			0: cmd = CMD_NOTE_OFF;
			1: cmd = CMD_NOTE_ON;
			2: cmd = CMD_CONTROLLER;
			3: cmd = CMD_PROGRAM;
			4: cmd = CMD_PRESSURE;
			default: cmd = CMD_BEND;
		endcase
		n = (cmd == CMD_PROGRAM || cmd == CMD_PRESSURE) ? 1 : 2;
		// Leave the status out now and then so that running status is exercised.
		if ($urandom_range(99) >= 35)
			send_byte({cmd, 4'($urandom_range(15))});
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0)
				send_byte(8'($urandom_range(255, 248)));
			if ($urandom_range(99) < 4)
				break;
			if ($urandom_range(7) == 0)
				send_byte(8'h00);
			else
				send_byte(8'($urandom_range(127)));
		end
	endtask

	logic [7:0] directed_bytes [26] = '{
		8'h45,                      // data with no running status
		8'h90, 8'h3C, 8'h7F,        // note on
		8'h3C, 8'h00,               // running status, velocity zero
		8'h8F, 8'h7F, 8'h40,        // note off on the top channel
		8'hB3, 8'h07, 8'hF8, 8'h64, // clock byte inside a controller message
		8'hE5, 8'h00, 8'h00,        // lowest bend
		8'h7F, 8'h7F,               // highest bend
		8'hC2, 8'h05, 8'h7F,        // program, then again by running status
		8'hD9, 8'h00,               // pressure
		8'hF0, 8'h12,               // system status clears the running status
		8'hFF
	};

	initial begin
		board          = new();
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		midi_byte      = 8'h00;
		out_ready      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		counted_bytes  = 0;
		quiet_cycles   = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_bytes[i])
			send_byte(directed_bytes[i]);
		// A partial note is dropped by a new status, then a status the parser does not handle clears all.
		send_byte(8'h91);
		send_byte(8'h10);
		send_byte(8'hB0);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'hA0);
		send_byte(8'h10);
		send_byte(8'hF7);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 48;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 48;
				end
				default: begin
					send_idle_pct  = 8;
					recv_stall_pct = 8;
				end
			endcase
			counted_bytes = 0;
			while (counted_bytes < PHASE_BYTES)
				send_random_message();
		end
		in_valid <= 1'b0;

		while (board.awaited_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
